// ===== sv/ethernet_ip_header_checker_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the header checker
// Shared assertion forms used at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef ETHERNET_IP_HEADER_CHECKER_DEFINES_SVH
`define ETHERNET_IP_HEADER_CHECKER_DEFINES_SVH
`define EIHC_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
`define EIHC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ===== sv/eihc_pkg.sv =====
// ----------------------------------------------------------------------------
// Header checker package
// Types and constants shared by the parser, the queue and the top level.
// ----------------------------------------------------------------------------
package eihc_pkg;
  localparam int unsigned QueueDepth = 3;

  localparam logic [15:0] EtypeIpv4 = 16'h0800;
  localparam logic [15:0] EtypeArp  = 16'h0806;
  localparam logic [7:0]  ProtoIcmp = 8'd1;
  localparam logic [7:0]  ProtoTcp  = 8'd6;
  localparam logic [7:0]  ProtoUdp  = 8'd17;

  localparam logic [1:0] KindIpv4 = 2'd0;
  localparam logic [1:0] KindArp  = 2'd1;
  localparam logic [1:0] KindUnk  = 2'd2;
  localparam logic [1:0] TrIcmp   = 2'd0;
  localparam logic [1:0] TrTcp    = 2'd1;
  localparam logic [1:0] TrUdp    = 2'd2;
  localparam logic [1:0] TrNone   = 2'd3;

  typedef struct packed {
    logic [1:0]  frame_kind;
    logic [1:0]  transport_kind;
    logic [5:0]  ip_header_bytes;
    logic [7:0]  type_of_service;
    logic [7:0]  time_to_live;
    logic        ip_checksum_good;
    logic [15:0] source_port;
    logic [15:0] dest_port;
    logic [7:0]  tcp_flag_bits;
    logic        tcp_checksum_good;
    logic [15:0] type_code;
    logic        truncated;
  } result_t;

  function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[15:0] + {15'd0, s[16]};
  endfunction
endpackage

// ===== sv/eihc_parser.sv =====
// ----------------------------------------------------------------------------
// Header checker byte parser
// Takes one frame byte per transfer, keeps running sums and captured fields,
// and builds the summary result on the last byte.
// ----------------------------------------------------------------------------
module eihc_parser (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                take_i,
  input  logic [7:0]          frame_byte_i,
  input  logic                last_byte_i,
  output logic                res_valid_o,
  output eihc_pkg::result_t   res_o
);
  logic [15:0] pos_q, pos_d;
  logic [15:0] etype_q, etype_d;
  logic [3:0]  ihl_q, ihl_d;
  logic [15:0] tlen_q, tlen_d;
  logic [7:0]  proto_q, proto_d, tos_q, tos_d, ttl_q, ttl_d, held_q;
  logic [15:0] ipsum_q, ipsum_d, segsum_q, segsum_d;
  logic [31:0] ports_q, ports_d;
  logic [23:0] fc_q, fc_d;

  logic [15:0] word, hdr, start, seglen, seg1, seg2;
  logic [16:0] start_ext, seg_end, need, len, cand;
  logic        step;
  eihc_pkg::result_t r;

  always_comb begin
    step = pos_q != 16'hFFFF;
    word = pos_q[0] ? {8'd0, frame_byte_i} : {frame_byte_i, 8'd0};
    etype_d = etype_q; ihl_d = ihl_q; tos_d = tos_q; tlen_d = tlen_q;
    fc_d = fc_q; ttl_d = ttl_q; proto_d = proto_q;
    ipsum_d = ipsum_q; segsum_d = segsum_q; ports_d = ports_q;
    pos_d = pos_q;
    if (step) begin
      pos_d = pos_q + 16'd1;
      if (pos_q == 16'd13) etype_d = {held_q, frame_byte_i};
      if (pos_q == 16'd14) ihl_d = frame_byte_i[3:0];
      if (pos_q == 16'd15) tos_d = frame_byte_i;
      if (pos_q == 16'd17) tlen_d = {held_q, frame_byte_i};
      if (pos_q == 16'd20) fc_d[15:8] = frame_byte_i;
      if (pos_q == 16'd21) fc_d[7:0] = frame_byte_i;
      if (pos_q == 16'd22) ttl_d = frame_byte_i;
      if (pos_q == 16'd23) proto_d = frame_byte_i;
    end
    hdr = {10'd0, ihl_d, 2'b00};
    start = 16'd14 + hdr;
    seglen = tlen_d - hdr;
    start_ext = {1'b0, start};
    seg_end = start_ext + {1'b0, seglen};
    if (step) begin
      if (pos_q >= 16'd14 && pos_q < start) ipsum_d = eihc_pkg::oc_add(ipsum_q, word);
      seg1 = (pos_q >= 16'd26 && pos_q <= 16'd33) ? eihc_pkg::oc_add(segsum_q, word)
                                                  : segsum_q;
      seg2 = (pos_q >= 16'd18 && pos_q >= start && {1'b0, pos_q} < seg_end)
             ? eihc_pkg::oc_add(seg1, word) : seg1;
      segsum_d = seg2;
      if (pos_q >= start && {1'b0, pos_q} < start_ext + 17'd4)
        ports_d = {ports_q[23:0], frame_byte_i};
      if ({1'b0, pos_q} == start_ext + 17'd13) fc_d[23:16] = frame_byte_i;
    end else begin
      seg1 = segsum_q;
      seg2 = segsum_q;
    end
    len = {1'b0, pos_d};
    r = '0;
    r.frame_kind = eihc_pkg::KindUnk;
    r.transport_kind = eihc_pkg::TrNone;
    need = 17'd0;
    cand = 17'd0;
    if (len < 17'd14) begin
      r.truncated = 1'b1;
    end else if (etype_d == eihc_pkg::EtypeIpv4) begin
      r.frame_kind = eihc_pkg::KindIpv4;
      r.ip_header_bytes = {ihl_d, 2'b00};
      r.type_of_service = tos_d;
      r.time_to_live = ttl_d;
      r.ip_checksum_good = ipsum_d == 16'hFFFF;
      need = 17'd14 + {1'b0, tlen_d};
      if (need < 17'd34) need = 17'd34;
      if (proto_d == eihc_pkg::ProtoIcmp) begin
        r.transport_kind = eihc_pkg::TrIcmp;
        r.type_code = {8'd0, ports_d[31:24]};
        cand = start_ext + 17'd2;
      end else if (proto_d == eihc_pkg::ProtoTcp) begin
        r.transport_kind = eihc_pkg::TrTcp;
        r.source_port = ports_d[31:16];
        r.dest_port = ports_d[15:0];
        r.tcp_flag_bits = fc_d[23:16];
        r.tcp_checksum_good = eihc_pkg::oc_add(eihc_pkg::oc_add(segsum_d,
                              {8'd0, proto_d}), seglen) == 16'hFFFF;
        cand = (seg_end > start_ext + 17'd20) ? seg_end : start_ext + 17'd20;
      end else if (proto_d == eihc_pkg::ProtoUdp) begin
        r.transport_kind = eihc_pkg::TrUdp;
        r.source_port = ports_d[31:16];
        r.dest_port = ports_d[15:0];
        cand = start_ext + 17'd8;
      end
      if (cand > need) need = cand;
      r.truncated = len < need;
    end else if (etype_d == eihc_pkg::EtypeArp) begin
      r.frame_kind = eihc_pkg::KindArp;
      r.type_code = fc_d[15:0];
      r.truncated = len < 17'd42;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0; etype_q <= '0; ihl_q <= '0; tlen_q <= '0; proto_q <= '0;
      tos_q <= '0; ttl_q <= '0; ipsum_q <= '0; segsum_q <= '0; held_q <= '0;
      ports_q <= '0; fc_q <= '0; res_valid_o <= 1'b0;
    end else begin
      res_valid_o <= take_i && last_byte_i;
      if (take_i) begin
        if (last_byte_i) begin
          pos_q <= '0; etype_q <= '0; ihl_q <= '0; tlen_q <= '0; proto_q <= '0;
          tos_q <= '0; ttl_q <= '0; ipsum_q <= '0; segsum_q <= '0; held_q <= '0;
          ports_q <= '0; fc_q <= '0;
        end else begin
          pos_q <= pos_d; etype_q <= etype_d; ihl_q <= ihl_d; tlen_q <= tlen_d;
          proto_q <= proto_d; tos_q <= tos_d; ttl_q <= ttl_d; ipsum_q <= ipsum_d;
          segsum_q <= segsum_d; ports_q <= ports_d; fc_q <= fc_d;
          if (step) held_q <= frame_byte_i;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_i && last_byte_i) res_o <= r;
  end
endmodule

// ===== sv/eihc_queue.sv =====
// ----------------------------------------------------------------------------
// Header checker result queue
// Small FIFO between the parser and the output port.
// ----------------------------------------------------------------------------
module eihc_queue #(
  parameter int unsigned Depth = eihc_pkg::QueueDepth
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  eihc_pkg::result_t data_i,
  output logic              valid_o,
  input  logic              pop_i,
  output eihc_pkg::result_t data_o,
  output logic [$clog2(Depth+1)-1:0] count_o
);
  localparam int unsigned Aw = (Depth > 1) ? $clog2(Depth) : 1;
  eihc_pkg::result_t mem_q [Depth];
  logic [Aw-1:0] wr_q, rd_q;
  logic [$clog2(Depth+1)-1:0] cnt_q;

  assign valid_o = cnt_q != '0;
  assign data_o  = mem_q[rd_q];
  assign count_o = cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0; rd_q <= '0; cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= (wr_q == Aw'(Depth - 1)) ? '0 : wr_q + 1'b1;
      if (pop_i) rd_q <= (rd_q == Aw'(Depth - 1)) ? '0 : rd_q + 1'b1;
      if (push_i && !pop_i) cnt_q <= cnt_q + 1'b1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end
endmodule

// ===== sv/ethernet_ip_header_checker.sv =====
// ----------------------------------------------------------------------------
// Ethernet IPv4 header checker
// Parses a byte-wide frame and reports one header summary per frame.
// ----------------------------------------------------------------------------
// The block takes one frame byte per cycle unless in_stall_o holds a last byte
// back, and out_valid_o follows via the parser's result register and the queue.
// The parser keeps all sums in place per byte; a result queue of QueueDepth
// entries lets the parser run on while results wait. Only a last byte is ever
// stalled, and only when the queue together with the pending result could
// overflow, so with a free output even one-byte frames pass back to back.
`include "ethernet_ip_header_checker_defines.svh"
module ethernet_ip_header_checker #(
  parameter int unsigned QueueDepth = eihc_pkg::QueueDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  frame_byte_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  frame_kind_o,
  output logic [1:0]  transport_kind_o,
  output logic [5:0]  ip_header_bytes_o,
  output logic [7:0]  type_of_service_o,
  output logic [7:0]  time_to_live_o,
  output logic        ip_checksum_good_o,
  output logic [15:0] source_port_o,
  output logic [15:0] dest_port_o,
  output logic [7:0]  tcp_flag_bits_o,
  output logic        tcp_checksum_good_o,
  output logic [15:0] type_code_o,
  output logic        truncated_o
);
  logic take, res_valid, pop;
  logic [$clog2(QueueDepth+1)-1:0] count;
  eihc_pkg::result_t res, head;

  assign in_stall_o = last_byte_i &&
    ({1'b0, count} + {{($clog2(QueueDepth+1)){1'b0}}, res_valid}
     >= ($clog2(QueueDepth+1)+1)'(QueueDepth));
  assign take = in_valid_i && !in_stall_o;
  assign pop  = out_valid_o && !out_stall_i;

  eihc_parser u_parser (
    .clk_i, .rst_ni, .take_i(take), .frame_byte_i, .last_byte_i,
    .res_valid_o(res_valid), .res_o(res)
  );

  eihc_queue #(.Depth(QueueDepth)) u_queue (
    .clk_i, .rst_ni, .push_i(res_valid), .data_i(res), .valid_o(out_valid_o),
    .pop_i(pop), .data_o(head), .count_o(count)
  );

  assign frame_kind_o        = head.frame_kind;
  assign transport_kind_o    = head.transport_kind;
  assign ip_header_bytes_o   = head.ip_header_bytes;
  assign type_of_service_o   = head.type_of_service;
  assign time_to_live_o      = head.time_to_live;
  assign ip_checksum_good_o  = head.ip_checksum_good;
  assign source_port_o       = head.source_port;
  assign dest_port_o         = head.dest_port;
  assign tcp_flag_bits_o     = head.tcp_flag_bits;
  assign tcp_checksum_good_o = head.tcp_checksum_good;
  assign type_code_o         = head.type_code;
  assign truncated_o         = head.truncated;

  `EIHC_ASSERT_NEXT(a_last_gives_result, clk_i, rst_ni, take && last_byte_i, res_valid)
  `EIHC_ASSERT_NEXT(a_result_needs_last, clk_i, rst_ni, !(take && last_byte_i), !res_valid)
  `EIHC_ASSERT_IMPL(a_no_overflow, clk_i, rst_ni, res_valid,
    (count != ($clog2(QueueDepth+1))'(QueueDepth)) || pop)
  `EIHC_ASSERT_IMPL(a_non_ip_fields, clk_i, rst_ni,
    out_valid_o && frame_kind_o != eihc_pkg::KindIpv4,
    transport_kind_o == eihc_pkg::TrNone && ip_header_bytes_o == 6'd0)
endmodule

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// Header checker testbench
// Sends byte-wide Ethernet frames into the checker and checks each summary.
// Expected summaries come from a byte-level model kept here. Frames cover
// IPv4 with TCP, UDP, ICMP and other protocols, ARP, unknown types, short
// frames and bad checksums. The run also applies random input gaps, output
// stalls and one long output hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module testbench;
  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  frame_byte_i = '0;
  logic        last_byte_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [1:0]  frame_kind_o;
  logic [1:0]  transport_kind_o;
  logic [5:0]  ip_header_bytes_o;
  logic [7:0]  type_of_service_o;
  logic [7:0]  time_to_live_o;
  logic        ip_checksum_good_o;
  logic [15:0] source_port_o;
  logic [15:0] dest_port_o;
  logic [7:0]  tcp_flag_bits_o;
  logic        tcp_checksum_good_o;
  logic [15:0] type_code_o;
  logic        truncated_o;

  ethernet_ip_header_checker dut (.*);

  always #2 clk_i = ~clk_i;

  eihc_pkg::result_t summary_queue[$];
  int unsigned mismatches = 0;
  int unsigned idle_cycles = 0;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  bit          hold_off = 1'b0;
  bit          timed_out = 1'b0;

  logic [15:0] pos, ether_kind, ip_total_len, ip_acc, seg_acc;
  logic [3:0]  ihl;
  logic [7:0]  proto, tos, ttl, prev_byte;
  logic [31:0] ports;
  logic [23:0] flags_code;

  function automatic logic [15:0] fold_add(logic [15:0] a, logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[15:0] + {15'd0, s[16]};
  endfunction

  task automatic clear_parser();
    pos = '0; ether_kind = '0; ip_total_len = '0; ip_acc = '0; seg_acc = '0;
    ihl = '0; proto = '0; tos = '0; ttl = '0; prev_byte = '0;
    ports = '0; flags_code = '0;
  endtask

  task automatic parse_byte(input logic [7:0] b);
    logic [15:0] word;
    int unsigned p, hdr, start, seglen;
    p = pos;
    word = p[0] ? {8'd0, b} : {b, 8'd0};
    if (p == 13) ether_kind = {prev_byte, b};
    if (p == 14) ihl = b[3:0];
    if (p == 15) tos = b;
    if (p == 17) ip_total_len = {prev_byte, b};
    if (p == 20) flags_code[15:8] = b;
    if (p == 21) flags_code[7:0] = b;
    if (p == 22) ttl = b;
    if (p == 23) proto = b;
    hdr = ihl * 4;
    start = 14 + hdr;
    seglen = (ip_total_len - hdr) & 16'hffff;
    if (p >= 14 && p < start) ip_acc = fold_add(ip_acc, word);
    if (p >= 26 && p <= 33) seg_acc = fold_add(seg_acc, word);
    if (p >= 18 && p >= start && p < start + seglen) seg_acc = fold_add(seg_acc, word);
    if (p >= start && p < start + 4) ports = {ports[23:0], b};
    if (p == start + 13) flags_code[23:16] = b;
    prev_byte = b;
  endtask

  task automatic predict_byte(input logic [7:0] b, input logic last);
    eihc_pkg::result_t r;
    int unsigned len, hdr, start, seglen, need;
    logic [15:0] s;
    if (pos != 16'hffff) begin
      parse_byte(b);
      pos++;
    end
    if (!last) return;
    r = '0;
    r.frame_kind = eihc_pkg::KindUnk;
    r.transport_kind = eihc_pkg::TrNone;
    len = pos;
    if (len < 14) begin
      r.truncated = 1'b1;
    end else if (ether_kind == eihc_pkg::EtypeIpv4) begin
      hdr = ihl * 4;
      start = 14 + hdr;
      seglen = (ip_total_len - hdr) & 16'hffff;
      need = (14 + ip_total_len > 34) ? 14 + ip_total_len : 34;
      r.frame_kind = eihc_pkg::KindIpv4;
      r.ip_header_bytes = hdr[5:0];
      r.type_of_service = tos;
      r.time_to_live = ttl;
      r.ip_checksum_good = (ip_acc == 16'hffff);
      if (proto == eihc_pkg::ProtoIcmp) begin
        r.transport_kind = eihc_pkg::TrIcmp;
        r.type_code = {8'd0, ports[31:24]};
        if (start + 2 > need) need = start + 2;
      end else if (proto == eihc_pkg::ProtoTcp) begin
        s = fold_add(fold_add(seg_acc, {8'd0, proto}), seglen[15:0]);
        r.transport_kind = eihc_pkg::TrTcp;
        r.source_port = ports[31:16];
        r.dest_port = ports[15:0];
        r.tcp_flag_bits = flags_code[23:16];
        r.tcp_checksum_good = (s == 16'hffff);
        if (start + 20 > need) need = start + 20;
        if (start + seglen > need) need = start + seglen;
      end else if (proto == eihc_pkg::ProtoUdp) begin
        r.transport_kind = eihc_pkg::TrUdp;
        r.source_port = ports[31:16];
        r.dest_port = ports[15:0];
        if (start + 8 > need) need = start + 8;
      end
      r.truncated = (len < need);
    end else if (ether_kind == eihc_pkg::EtypeArp) begin
      r.frame_kind = eihc_pkg::KindArp;
      r.type_code = flags_code[15:0];
      r.truncated = (len < 42);
    end
    summary_queue.push_back(r);
    clear_parser();
  endtask

  task automatic send_byte(input logic [7:0] b, input logic last);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    frame_byte_i <= b;
    last_byte_i <= last;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_byte(b, last);
    @(negedge clk_i);
  endtask

  task automatic send_frame(input logic [7:0] f[$]);
    foreach (f[i]) send_byte(f[i], i == f.size() - 1);
  endtask

  // Builds an IPv4 frame; fix_sums (ihl_v >= 5) makes the IP and any full TCP checksum valid.
  task automatic build_ipv4(output logic [7:0] f[$], input logic [3:0] ihl_v,
                            input logic [7:0] proto_v, input int unsigned payload,
                            input bit fix_sums, input int signed len_adj,
                            input int signed cut);
    logic [15:0] s, tl;
    int unsigned n, hl, tstart, i;
    hl = ihl_v * 4;
    n = 14 + (hl < 20 ? 20 : hl) + payload;
    f = {};
    for (i = 0; i < n; i++) f.push_back(8'($urandom_range(255)));
    f[12] = 8'h08; f[13] = 8'h00;
    f[14] = {4'h4, ihl_v};
    tl = 16'(n - 14 + len_adj);
    f[16] = tl[15:8]; f[17] = tl[7:0];
    f[23] = proto_v;
    tstart = 14 + hl;
    if (fix_sums && ihl_v >= 5) begin
      if (proto_v == eihc_pkg::ProtoTcp && tl >= hl && n >= tstart + 20) begin
        f[tstart + 16] = 8'd0; f[tstart + 17] = 8'd0;
        s = fold_add(16'd0, {8'd0, proto_v});
        s = fold_add(s, 16'(tl - hl));
        for (i = 26; i < 34; i += 2) s = fold_add(s, {f[i], f[i + 1]});
        for (i = tstart; i < 14 + tl && i < n; i += 2)
          s = fold_add(s, {f[i], (i + 1 < 14 + tl && i + 1 < n) ? f[i + 1] : 8'd0});
        s = ~s;
        f[tstart + 16] = s[15:8]; f[tstart + 17] = s[7:0];
      end
      f[24] = 8'd0; f[25] = 8'd0;
      s = '0;
      for (i = 14; i < tstart; i += 2) s = fold_add(s, {f[i], f[i + 1]});
      s = ~s;
      f[24] = s[15:8]; f[25] = s[7:0];
    end
    while (cut > 0 && f.size() > 1) begin
      void'(f.pop_back());
      cut--;
    end
  endtask

  task automatic random_frame();
    logic [7:0] f[$];
    logic [7:0] protos[4] = '{eihc_pkg::ProtoTcp, eihc_pkg::ProtoUdp,
                              eihc_pkg::ProtoIcmp, 8'd0};
    int unsigned sel, i, n;
    sel = $urandom_range(99);
    if (sel < 70) begin
      build_ipv4(f, $urandom_range(9) < 8 ? 4'd5 : 4'($urandom_range(15)),
                 $urandom_range(9) < 9 ? protos[$urandom_range(3)] : 8'($urandom),
                 $urandom_range(40), $urandom_range(9) < 8,
                 $urandom_range(9) < 8 ? 0 : $urandom_range(8) - 4,
                 $urandom_range(9) < 8 ? 0 : $urandom_range(6));
      if ($urandom_range(19) == 0) f[$urandom_range(f.size() - 1)] ^= 8'($urandom);
    end else if (sel < 85) begin
      n = $urandom_range(30, 50);
      for (i = 0; i < n; i++) f.push_back(8'($urandom_range(255)));
      f[12] = 8'h08; f[13] = 8'h06;
    end else begin
      n = $urandom_range(1, 30);
      for (i = 0; i < n; i++) f.push_back(8'($urandom_range(255)));
    end
    send_frame(f);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (summary_queue.size() != 0 && !timed_out) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic test_directed();
    logic [7:0] f[$];
    int i;
    send_idle_pct = 0; stall_pct = 0;
    build_ipv4(f, 4'd5, eihc_pkg::ProtoTcp, 12, 1, 0, 0); send_frame(f);
    build_ipv4(f, 4'd15, eihc_pkg::ProtoTcp, 21, 1, 0, 0); send_frame(f);
    build_ipv4(f, 4'd6, eihc_pkg::ProtoUdp, 8, 1, 0, 0); send_frame(f);
    build_ipv4(f, 4'd5, eihc_pkg::ProtoIcmp, 4, 1, 0, 0); send_frame(f);
    build_ipv4(f, 4'd5, 8'd255, 2, 1, 0, 0); send_frame(f);
    build_ipv4(f, 4'd5, eihc_pkg::ProtoTcp, 20, 0, 0, 0); send_frame(f);
    build_ipv4(f, 4'd5, eihc_pkg::ProtoTcp, 20, 1, 0, 5); send_frame(f);
    build_ipv4(f, 4'd0, eihc_pkg::ProtoTcp, 10, 0, 0, 0); send_frame(f);
    build_ipv4(f, 4'd2, eihc_pkg::ProtoUdp, 10, 0, 0, 0); send_frame(f);
    build_ipv4(f, 4'd5, eihc_pkg::ProtoTcp, 20, 0, -30, 0); send_frame(f);
    build_ipv4(f, 4'd5, eihc_pkg::ProtoTcp, 20, 0, 20, 0); send_frame(f);
    f = {}; for (i = 0; i < 42; i++) f.push_back(8'hff);
    f[12] = 8'h08; f[13] = 8'h06; send_frame(f);
    f = {}; for (i = 0; i < 42; i++) f.push_back(8'h00);
    f[12] = 8'h08; f[13] = 8'h06; f[20] = 8'h00; f[21] = 8'h02; send_frame(f);
    f = {}; for (i = 0; i < 30; i++) f.push_back(8'h00);
    f[12] = 8'h08; f[13] = 8'h06; send_frame(f);
    f = {8'h55}; send_frame(f);
    f = {}; for (i = 0; i < 13; i++) f.push_back(8'haa); send_frame(f);
    f = {}; for (i = 0; i < 14; i++) f.push_back(8'h5a); send_frame(f);
    wait_drained();
  endtask

  task automatic test_random(input int unsigned frames, input int unsigned idle,
                             input int unsigned stall);
    send_idle_pct = idle; stall_pct = stall;
    repeat (frames) random_frame();
    wait_drained();
  endtask

  task automatic test_backpressure();
    int unsigned i;
    send_idle_pct = 0; stall_pct = 0;
    hold_off = 1'b1;
    for (i = 0; i < 4; i++) random_frame();
    wait_drained();
  endtask

  always @(negedge clk_i) begin
    if (hold_off) out_stall_i <= 1'b1;
    else out_stall_i <= stall_pct != 0 && $urandom_range(99) < stall_pct;
  end

  initial begin : hold_off_timer
    forever begin
      @(posedge clk_i);
      if (hold_off) begin
        repeat (600) @(posedge clk_i);
        hold_off = 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    eihc_pkg::result_t got, want;
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || hold_off)
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (out_valid_o && !out_stall_i) begin
        got = '{frame_kind_o, transport_kind_o, ip_header_bytes_o, type_of_service_o,
                time_to_live_o, ip_checksum_good_o, source_port_o, dest_port_o,
                tcp_flag_bits_o, tcp_checksum_good_o, type_code_o, truncated_o};
        if (summary_queue.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result transfer: %p", got);
        end else begin
          want = summary_queue.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch: expected %p, actual %p", want, got);
          end
        end
      end
    end
  end

  initial begin : watchdog
    wait (idle_cycles >= 5000);
    timed_out = 1'b1;
    $display("simulation failed");
    $finish;
  end

  initial begin
    clear_parser();
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed();
    test_random(3, 0, 0);
    test_random(3, 62, 0);
    test_random(3, 0, 62);
    test_random(3, 11, 11);
    test_backpressure();
    test_random(2, 0, 0);
    if (summary_queue.size() != 0) mismatches++;
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule

// ===== files.f =====
+incdir+sv
sv/eihc_pkg.sv
sv/eihc_parser.sv
sv/eihc_queue.sv
sv/ethernet_ip_header_checker.sv
verif/testbench.sv
